// File: src/hs_pkg.sv
// hs_pkg: shared types, sizes and the microcode store of the heap sorter.
// Depends on nothing; used by heap_sorter and hs_checker.
package hs_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = ADDR_W + 2;
   localparam int DATA_W = 32;
   localparam int PC_W   = 5;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } rsp_type;

   typedef logic [PC_W-1:0] pc_type;

   // micro-operations driving the datapath
   typedef enum logic [4:0] {
      U_COLLECT,
      U_BINIT,
      U_BTEST,
      U_LOADN,
      U_SL,
      U_SR,
      U_SC,
      U_SEND,
      U_NOP,
      U_XINIT,
      U_XTEST,
      U_XA,
      U_XB,
      U_EINIT,
      U_EREAD,
      U_ELOAD,
      U_EDONE
   } uop_type;

   // sequencing: step on, jump always, jump on flag, jump on flag clear
   typedef enum logic [1:0] {
      C_NEXT,
      C_GOTO,
      C_JF,
      C_JNF
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   // program addresses
   localparam pc_type ST_COLLECT = 5'd0;
   localparam pc_type ST_BINIT   = 5'd1;
   localparam pc_type ST_BTEST   = 5'd2;
   localparam pc_type ST_LOADN   = 5'd3;
   localparam pc_type ST_SL      = 5'd4;
   localparam pc_type ST_SR      = 5'd5;
   localparam pc_type ST_SC      = 5'd6;
   localparam pc_type ST_SEND    = 5'd7;
   localparam pc_type ST_BRET    = 5'd8;
   localparam pc_type ST_XINIT   = 5'd9;
   localparam pc_type ST_XTEST   = 5'd10;
   localparam pc_type ST_XA      = 5'd11;
   localparam pc_type ST_XB      = 5'd12;
   localparam pc_type ST_EINIT   = 5'd13;
   localparam pc_type ST_EREAD   = 5'd14;
   localparam pc_type ST_ELOAD   = 5'd15;
   localparam pc_type ST_EDONE   = 5'd16;

   // read-only control store
   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type w;
      unique case (pc)
         ST_COLLECT: w = '{U_COLLECT, C_NEXT, ST_COLLECT};
         ST_BINIT:   w = '{U_BINIT,   C_NEXT, ST_BINIT};
         ST_BTEST:   w = '{U_BTEST,   C_JF,   ST_XINIT};
         ST_LOADN:   w = '{U_LOADN,   C_NEXT, ST_LOADN};
         ST_SL:      w = '{U_SL,      C_JF,   ST_SEND};
         ST_SR:      w = '{U_SR,      C_NEXT, ST_SR};
         ST_SC:      w = '{U_SC,      C_JNF,  ST_SL};
         ST_SEND:    w = '{U_SEND,    C_JF,   ST_XTEST};
         ST_BRET:    w = '{U_NOP,     C_GOTO, ST_BTEST};
         ST_XINIT:   w = '{U_XINIT,   C_NEXT, ST_XINIT};
         ST_XTEST:   w = '{U_XTEST,   C_JF,   ST_EINIT};
         ST_XA:      w = '{U_XA,      C_NEXT, ST_XA};
         ST_XB:      w = '{U_XB,      C_GOTO, ST_SL};
         ST_EINIT:   w = '{U_EINIT,   C_NEXT, ST_EINIT};
         ST_EREAD:   w = '{U_EREAD,   C_NEXT, ST_EREAD};
         ST_ELOAD:   w = '{U_ELOAD,   C_JNF,  ST_EREAD};
         ST_EDONE:   w = '{U_EDONE,   C_GOTO, ST_COLLECT};
         default:    w = '{U_NOP,     C_GOTO, ST_COLLECT};
      endcase
      return w;
   endfunction

endpackage

// File: src/hs_ram.sv
// hs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/heap_sorter.sv
// heap_sorter: heapsort engine with a microcoded sequencer and one element store.
// Depends on hs_pkg and hs_ram.
// Collect: one beat per cycle while collecting; none while sorting or emitting.
// Sort: each sift level reads the left child, reads the right child, then compares
// and moves, bound by the single read port of the store. Emit: each result beat is
// read from the store, then loaded into the result register. Synchronous reset clears
// the sequencer, the count, the overflow mark and the result valid; no store clear.
module heap_sorter (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hs_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hs_pkg::rsp_type rsp_data
);
   import hs_pkg::*;

   // sequencer
   pc_type   pc_ff, pc_in;
   ctrl_type ctrl;
   logic     flag, stall;

   // datapath registers
   logic [CNT_W-1:0]         cnt_ff, cnt_in;    // elements stored in this set
   logic                     ovf_ff, ovf_in;    // a beat of this set was dropped
   logic [CNT_W-1:0]         len_ff, len_in;    // current heap length
   logic [CNT_W-1:0]         k_ff, k_in;        // build index / extract length
   logic [ADDR_W-1:0]        node_ff, node_in;  // hole being sifted
   logic signed [DATA_W-1:0] nval_ff, nval_in;  // value travelling down
   logic signed [DATA_W-1:0] lval_ff, lval_in;  // left child value
   logic                     xtr_ff, xtr_in;    // extract phase
   logic [CNT_W-1:0]         e_ff, e_in;        // emit index
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // store port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   // child indices, wide enough for the right child of the last node
   logic [IDX_W-1:0]  left, right, len_x;
   logic              right_ok, l_gt, r_gt;
   logic signed [DATA_W-1:0] best1, r_val;
   logic [IDX_W-1:0]  top1, top;
   logic [CNT_W-1:0]  km1, e_nx;
   logic              accept, full, rsp_free;

   assign ctrl     = ucode(pc_ff);
   assign req_ready = (ctrl.uop == U_COLLECT);
   assign accept   = req_valid && req_ready;
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign left     = IDX_W'({node_ff, 1'b0}) + IDX_W'(1);
   assign right    = left + IDX_W'(1);
   assign len_x    = IDX_W'(len_ff);
   assign right_ok = (right < len_x);
   assign km1      = k_ff - CNT_W'(1);
   assign e_nx     = e_ff + CNT_W'(1);

   // pick the largest of hole value, left child and right child
   assign r_val = $signed(rd_data);
   assign l_gt  = (lval_ff > nval_ff);
   assign best1 = l_gt ? lval_ff : nval_ff;
   assign top1  = l_gt ? left : IDX_W'(node_ff);
   assign r_gt  = right_ok && (r_val > best1);
   assign top   = r_gt ? right : top1;

   // next step
   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else begin
         case (ctrl.cond)
            C_GOTO:  pc_in = ctrl.target;
            C_JF:    pc_in = flag ? ctrl.target : pc_ff + pc_type'(1);
            C_JNF:   pc_in = !flag ? ctrl.target : pc_ff + pc_type'(1);
            default: pc_in = pc_ff + pc_type'(1);
         endcase
      end
   end

   // datapath controls per micro-op
   always_comb begin
      flag         = 1'b0;
      stall        = 1'b0;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      node_in      = node_ff;
      nval_in      = nval_ff;
      lval_in      = lval_ff;
      xtr_in       = xtr_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = nval_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;

      unique case (ctrl.uop)
         U_COLLECT: begin
            stall = !(accept && req_data.last_item);
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[ADDR_W-1:0];
                  wr_data = req_data.value;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
            end
         end
         U_BINIT: begin
            len_in = cnt_ff;
            k_in   = cnt_ff >> 1;
            xtr_in = 1'b0;
         end
         U_BTEST: begin
            flag    = (k_ff == '0);
            k_in    = km1;
            node_in = km1[ADDR_W-1:0];
            rd_en   = 1'b1;
            rd_addr = km1[ADDR_W-1:0];
         end
         U_LOADN: begin
            nval_in = $signed(rd_data);
         end
         U_SL: begin
            flag    = !(left < len_x);
            rd_en   = 1'b1;
            rd_addr = left[ADDR_W-1:0];
         end
         U_SR: begin
            lval_in = $signed(rd_data);
            rd_en   = right_ok;
            rd_addr = right[ADDR_W-1:0];
         end
         U_SC: begin
            // flag: hole already above both children
            flag = !l_gt && !r_gt;
            if (l_gt || r_gt) begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_data = r_gt ? r_val : lval_ff;
               node_in = top[ADDR_W-1:0];
            end
         end
         U_SEND: begin
            flag    = xtr_ff;
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = nval_ff;
         end
         U_NOP: begin
         end
         U_XINIT: begin
            k_in   = len_ff;
            xtr_in = 1'b1;
         end
         U_XTEST: begin
            flag    = (k_ff <= CNT_W'(1));
            k_in    = km1;
            rd_en   = 1'b1;
            rd_addr = km1[ADDR_W-1:0];
         end
         U_XA: begin
            // tail value becomes the hole at the root
            nval_in = $signed(rd_data);
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         U_XB: begin
            // old root (the maximum) parks at the tail
            wr_en   = 1'b1;
            wr_addr = k_ff[ADDR_W-1:0];
            wr_data = rd_data;
            len_in  = k_ff;
            node_in = '0;
         end
         U_EINIT: begin
            e_in = '0;
         end
         U_EREAD: begin
            rd_en   = 1'b1;
            rd_addr = e_ff[ADDR_W-1:0];
         end
         U_ELOAD: begin
            stall = !rsp_free;
            flag  = (e_nx == cnt_ff);
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = $signed(rd_data);
               rsp_data_in.last_out     = (e_nx == cnt_ff);
               rsp_data_in.overflow     = ovf_ff;
               e_in                     = e_nx;
            end
         end
         U_EDONE: begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_COLLECT;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      k_ff        <= k_in;
      node_ff     <= node_in;
      nval_ff     <= nval_in;
      lval_ff     <= lval_in;
      xtr_ff      <= xtr_in;
      e_ff        <= e_in;
      rsp_data_ff <= rsp_data_in;
   end

   hs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/hs_checker.sv
// hs_port_checker: port-level checks of the heap sorter's result stream, bound to the top.
// Depends on hs_pkg and heap_sorter.
module hs_port_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input hs_pkg::req_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input hs_pkg::rsp_type rsp_data
);
   import hs_pkg::*;

   logic                     rsp_beat;
   logic                     open_ff, open_in;
   logic signed [DATA_W-1:0] prev_val_ff, prev_val_in;
   logic                     prev_ovf_ff, prev_ovf_in;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      open_in     = open_ff;
      prev_val_in = prev_val_ff;
      prev_ovf_in = prev_ovf_ff;
      if (rsp_beat) begin
         open_in     = !rsp_data.last_out;
         prev_val_in = rsp_data.sorted_value;
         prev_ovf_in = rsp_data.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_val_ff <= prev_val_in;
      prev_ovf_ff <= prev_ovf_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered straight after reset");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && open_ff |-> rsp_data.sorted_value >= prev_val_ff)
      else $error("results of a set not in ascending order");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && open_ff |-> rsp_data.overflow == prev_ovf_ff)
      else $error("overflow flag changed within a set");

   // a waiting beat that is not the last of its set means emission is still under way
   a_no_input_mid_set: assert property (@(posedge clock) disable iff (reset)
      open_ff && rsp_valid && !rsp_data.last_out
         |-> !(req_valid && req_ready && req_data.last_item))
      else $error("set closed while a previous set was still being emitted");

endmodule

bind heap_sorter hs_port_checker u_hs_port_checker (.*);

// File: verif/hs_checker.sv
// hs_checker: watches both channels of heap_sorter, predicts every sorted set and checks
// each result beat against it. Depends on hs_pkg; instantiated by heap_sorter_tb.
module hs_checker
   import hs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   // values of the set being collected, sorted in place once it closes
   logic signed [DATA_W-1:0] held [DEPTH];
   int                       held_count;
   logic                     dropped_any;
   rsp_type                  sorted_due [$];

   // push one node down a max-heap of heap_len entries
   function automatic void sift_down(input int heap_len, input int start);
      int                       parent;
      int                       largest;
      int                       child;
      logic                     settled;
      logic signed [DATA_W-1:0] tmp;
      parent  = start;
      settled = 1'b0;
      while (!settled) begin
         largest = parent;
         child   = 2 * parent + 1;
         if (child < heap_len && held[child] > held[largest])
            largest = child;
         if (child + 1 < heap_len && held[child + 1] > held[largest])
            largest = child + 1;
         if (largest == parent) begin
            settled = 1'b1;
         end else begin
            tmp           = held[parent];
            held[parent]  = held[largest];
            held[largest] = tmp;
            parent        = largest;
         end
      end
   endfunction

   // heapify, then move the root to the shrinking tail: ascending order
   function automatic void sort_held(input int n);
      int                       k;
      logic signed [DATA_W-1:0] tmp;
      for (k = n / 2; k > 0; k--)
         sift_down(n, k - 1);
      for (k = n; k > 1; k--) begin
         tmp         = held[0];
         held[0]     = held[k - 1];
         held[k - 1] = tmp;
         sift_down(k - 1, 0);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      k;
      if (reset) begin
         held_count  = 0;
         dropped_any = 1'b0;
         sorted_due.delete();
         pending     = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (held_count < DEPTH) begin
               held[held_count] = req_data.value;
               held_count++;
            end else begin
               dropped_any = 1'b1;
            end
            if (req_data.last_item) begin
               sort_held(held_count);
               for (k = 0; k < held_count; k++) begin
                  want.sorted_value = held[k];
                  want.last_out     = (k == held_count - 1);
                  want.overflow     = dropped_any;
                  sorted_due.push_back(want);
               end
               held_count  = 0;
               dropped_any = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result beat with none due: value %0d last %b ovf %b",
                           $time, rsp_data.sorted_value, rsp_data.last_out,
                           rsp_data.overflow);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value ||
                   rsp_data.last_out !== want.last_out ||
                   rsp_data.overflow !== want.overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: want value %0d last %b ovf %b,",
                               " got value %0d last %b ovf %b"},
                              $time, want.sorted_value, want.last_out, want.overflow,
                              rsp_data.sorted_value, rsp_data.last_out,
                              rsp_data.overflow);
               end
            end
         end
         pending = sorted_due.size();
      end
   end

endmodule

// File: verif/heap_sorter_tb.sv
// heap_sorter_tb: stimulus and verdict for heap_sorter; the checking lives in hs_checker.
// Depends on hs_pkg, heap_sorter and hs_checker.
module heap_sorter_tb;
   import hs_pkg::*;

   localparam int ITEM_TARGET  = 330;     // request beats before the stimulus stops
   localparam int HOLD_AFTER   = 40;      // result beat after which the sink stalls
   localparam int HOLD_CYCLES  = 300;     // length of that stall
   localparam int DRAIN_CYCLES = 200;     // settle time once nothing is due
   localparam int LIMIT_CYCLES = 200000;  // far beyond the slowest legal run

   localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   int                       items_sent = 0;
   logic                     sender_eager = 1'b0;  // no gaps on the request side
   logic signed [DATA_W-1:0] set_vals [$];        // the set about to be sent

   heap_sorter i_dut (.*);

   hs_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop: any hang or a result that never turns up ends here
   initial begin
      #(2 * LIMIT_CYCLES);
      $display("** heap_sorter: FAILED **");
      $finish;
   end

   // Value mix: full-range noise, a narrow band so that sets hold duplicates, and the
   // extremes of the signed range, zero and minus one.
   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 3))
         0: begin
            v = $signed($urandom_range(0, 16)) - 32'sd8;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: v = MAX_V;
               1: v = MIN_V;
               2: v = '0;
               default: v = -32'sd1;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   // One request beat. We always enter and leave on a falling edge, so valid and data
   // change there and only there; a beat with no gap keeps valid high across the edge.
   task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic last);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: v, last_item: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // the last value of the set carries the end-of-set mark
   task automatic send_set();
      int i;
      for (i = 0; i < set_vals.size(); i++)
         send_beat(set_vals[i], i == set_vals.size() - 1);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
   endtask

   // request side: reset, directed sets, then random sets until the beat budget is spent
   initial begin : stimulus
      int set_no;
      int set_len;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-value sets at both ends of the range, then a pair of both
      set_vals = {MAX_V};
      send_set();
      set_vals = {MIN_V};
      send_set();
      set_vals = {MAX_V, MIN_V};
      send_set();
      // sign boundary around zero, mixed order
      set_vals = {32'sd0, -32'sd1, 32'sd1, MIN_V, MAX_V};
      send_set();
      // equal values: their relative order is invisible at the output
      set_vals = {32'sd5, 32'sd5, -32'sd5, 32'sd5};
      send_set();
      // already ascending, then strictly descending near the extremes
      set_vals = {-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
      send_set();
      set_vals = {MAX_V, MAX_V - 32'sd1, MIN_V + 32'sd1, MIN_V};
      send_set();

      // hold the request side until every directed result is back
      wait_drained();

      // Random sets, mostly short. One fills the store exactly; one overruns it by two,
      // so the beat carrying the end-of-set mark is itself dropped.
      set_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (set_no == 6)
            set_len = DEPTH;
         else if (set_no == 14)
            set_len = DEPTH + 2;
         else
            set_len = $urandom_range(1, 12);
         sender_eager = ($urandom_range(0, 3) == 0);
         set_vals.delete();
         repeat (set_len) set_vals.push_back(pick_value());
         send_set();
         set_no++;
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("** heap_sorter: PASSED **");
      else
         $display("** heap_sorter: FAILED **");
      $finish;
   end

   // Result side: random back-pressure with occasional gap-free stretches. After a fixed
   // number of beats it stalls for a long while, so the block backs up and the request
   // side sees ready held low.
   initial begin : sink
      int   taken;
      int   gap;
      logic sink_eager;
      taken      = 0;
      sink_eager = 1'b0;
      rsp_ready  = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            sink_eager = !sink_eager;
         gap = sink_eager ? 0 : $urandom_range(0, 13);
         if (taken == HOLD_AFTER)
            gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         taken++;
      end
   end

endmodule
